[rtl/byte_ring_buffer_block_access_unit_assert.svh]
// Assertion macros shared by the ring buffer modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef BYTE_RING_BUFFER_BLOCK_ACCESS_UNIT_ASSERT_SVH
`define BYTE_RING_BUFFER_BLOCK_ACCESS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds in the same cycle as the trigger.
`define BRB_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");
// Condition holds in the cycle after the trigger.
`define BRB_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define BRB_ASSERT_NOW(label, trig, cond)
`define BRB_ASSERT_NEXT(label, trig, cond)
`endif

`endif

[rtl/brb_pkg.sv]
`timescale 1ns / 1ps
package brb_pkg;

  localparam int DEPTH = 4096;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_NULL    = 2'd3
  } brb_mode_t;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_ROOM = 2'd1;
  localparam logic [1:0] STS_TOO_FEW = 2'd2;

  // Per-item command from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       wr;
    logic       rd_adv;
    logic       rd_sel;
    logic [1:0] status;
    logic       last;
  } brb_cmd_t;

  // Occupancy seen by the controller for the transaction check.
  typedef struct packed {
    logic [CW-1:0] free_room;
    logic [CW-1:0] held;
  } brb_stat_t;

endpackage

[rtl/brb_datapath.sv]
`timescale 1ns / 1ps
`include "byte_ring_buffer_block_access_unit_assert.svh"
module brb_datapath
  import brb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata,
  input  brb_cmd_t      cmd,
  input  logic [7:0]    data_in,
  output brb_stat_t     stat,
  output logic [7:0]    data_out,
  output logic [1:0]    status,
  output logic          last,
  output logic [CW-1:0] bytes_held
);

  logic [CW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q_r;
  logic          rd_sel_r;
  logic [1:0]    status_r;
  logic          last_r;
  logic [CW-1:0] held_r;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] n;
    n = {1'b0, p} + CW'(1);
    return (n >= cap) ? '0 : n[AW-1:0];
  endfunction

  always_comb begin
    if (cfg_wdata == '0) begin
      cap_nxt = CW'(1);
    end else if (cfg_wdata > CW'(DEPTH)) begin
      cap_nxt = CW'(DEPTH);
    end else begin
      cap_nxt = cfg_wdata;
    end
  end

  always_comb begin
    free_nxt = free_r;
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    if (cmd.wr) begin
      wp_nxt = advance(wp_r, cap_r);
      if (free_r != '0) free_nxt = free_r - CW'(1);
    end
    if (cmd.rd_adv) begin
      rp_nxt = advance(rp_r, cap_r);
      if (free_r < cap_r) free_nxt = free_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CW'(DEPTH);
      free_r <= CW'(DEPTH);
      wp_r   <= '0;
      rp_r   <= '0;
    end else if (cfg_we) begin
      cap_r  <= cap_nxt;
      free_r <= cap_nxt;
      wp_r   <= '0;
      rp_r   <= '0;
    end else begin
      free_r <= free_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[wp_r] <= data_in;
    if (cmd.rd_sel) mem_q_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_sel_r <= cmd.rd_sel;
      status_r <= cmd.status;
      last_r   <= cmd.last;
      held_r   <= cap_r - free_nxt;
    end
  end

  assign stat.free_room = free_r;
  assign stat.held      = cap_r - free_r;
  assign data_out       = rd_sel_r ? mem_q_r : 8'd0;
  assign status         = status_r;
  assign last           = last_r;
  assign bytes_held     = held_r;

  `BRB_ASSERT_NOW(a_room_bound, 1'b1, free_r <= cap_r)

endmodule

[rtl/brb_controller.sv]
`timescale 1ns / 1ps
`include "byte_ring_buffer_block_access_unit_assert.svh"
module brb_controller
  import brb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  brb_mode_t     mode,
  input  logic          first,
  input  logic [CW-1:0] count,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  brb_stat_t     stat,
  output brb_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPEN,
    S_REJ
  } state_t;

  state_t        state_r, state_nxt;
  brb_mode_t     mode_r, mode_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          acc, start, rej;
  logic [CW-1:0] cnt_eff, left_cur;
  brb_mode_t     mode_cur;

  assign in_tready = !out_tvalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign start     = first || (state_r == S_IDLE);
  assign cnt_eff   = (count == '0) ? CW'(1) : count;

  always_comb begin
    mode_cur = start ? mode : mode_r;
    left_cur = start ? cnt_eff : left_r;
    rej      = 1'b0;
    if (start) begin
      case (mode)
        MODE_WRITE:   rej = cnt_eff > stat.free_room;
        MODE_READ,
        MODE_DISCARD: rej = cnt_eff > stat.held;
        default:      rej = 1'b0;
      endcase
    end else begin
      rej = (state_r == S_REJ);
    end
  end

  always_comb begin
    cmd.load   = acc;
    cmd.wr     = acc && !rej && (mode_cur == MODE_WRITE);
    cmd.rd_adv = acc && !rej && (mode_cur inside {MODE_READ, MODE_DISCARD});
    cmd.rd_sel = acc && !rej && (mode_cur == MODE_READ);
    cmd.last   = (left_cur == CW'(1));
    if (!rej) begin
      cmd.status = STS_OK;
    end else if (mode_cur == MODE_WRITE) begin
      cmd.status = STS_NO_ROOM;
    end else begin
      cmd.status = STS_TOO_FEW;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    left_nxt       = left_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (cfg_we) begin
      state_nxt = S_IDLE;
      left_nxt  = '0;
    end else if (acc) begin
      out_tvalid_nxt = 1'b1;
      mode_nxt       = mode_cur;
      left_nxt       = left_cur - CW'(1);
      if (cmd.last) begin
        state_nxt = S_IDLE;
      end else if (rej) begin
        state_nxt = S_REJ;
      end else begin
        state_nxt = S_OPEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_WRITE;
      left_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      left_r       <= left_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  `BRB_ASSERT_NOW(a_idle_empty, state_r == S_IDLE, left_r == '0)
  `BRB_ASSERT_NOW(a_busy_left, state_r != S_IDLE, left_r != '0)
  `BRB_ASSERT_NOW(a_rej_frozen, acc && state_r == S_REJ && !first, !cmd.wr && !cmd.rd_adv)
  `BRB_ASSERT_NEXT(a_last_closes, acc && cmd.last && !cfg_we, state_r == S_IDLE)

endmodule

[rtl/byte_ring_buffer_block_access_unit.sv]
`timescale 1ns / 1ps
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the store takes one write or one
// registered read per item, and a stalled result holds the input side.
// Reset (synchronous, rst_n low): empty buffer, capacity 4096, no open
// transaction, no pending result. Store contents are left as they are.
module byte_ring_buffer_block_access_unit
  import brb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  // Capacity register, clamped to 1..4096; a write empties the buffer.
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [23:0]   in_tdata,   // count[12:0], data_in[20:13], zero pad
  input  logic [2:0]    in_tuser,   // mode[1:0], first[2]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [23:0]   out_tdata,  // data_out[7:0], bytes_held[20:8], zero pad
  output logic [1:0]    out_tuser,  // status[1:0]
  output logic          out_tlast   // last byte of the transaction
);

  // The controller owns the transaction state (remaining length, mode and
  // whether the transaction was turned away) and the output handshake. The
  // datapath owns the pointers, the free-room count, the store and the
  // result payload registers.
  brb_cmd_t      cmd;
  brb_stat_t     stat;
  logic [7:0]    data_out;
  logic [1:0]    status;
  logic          last;
  logic [CW-1:0] bytes_held;

  brb_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .mode       (brb_mode_t'(in_tuser[1:0])),
    .first      (in_tuser[2]),
    .count      (in_tdata[12:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  brb_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .data_in    (in_tdata[20:13]),
    .stat       (stat),
    .data_out   (data_out),
    .status     (status),
    .last       (last),
    .bytes_held (bytes_held)
  );

  // The padding bits of in_tdata carry nothing and are ignored.
  assign out_tdata = {3'b000, bytes_held, data_out};
  assign out_tuser = status;
  assign out_tlast = last;

endmodule
